// ----- rtl/mwd_pkg.sv -----
// types, constants and tables shared by the moisture wet/dry controller
package mwd_pkg;

  localparam int unsigned MvW     = 12;
  localparam int unsigned CntW    = 4;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned RepeatW = 15;
  localparam int unsigned DelayW  = 21;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  // phase codes
  localparam logic [PhaseW-1:0] PhDry    = 3'd0;
  localparam logic [PhaseW-1:0] PhJudge  = 3'd1;
  localparam logic [PhaseW-1:0] PhWet    = 3'd2;
  localparam logic [PhaseW-1:0] PhDryRun = 3'd3;
  localparam logic [PhaseW-1:0] PhCc     = 3'd4;

  // request codes
  localparam logic ReqStart   = 1'b0;
  localparam logic ReqMeasure = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWetThr    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgShortThr  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGroundThr = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLogoMode  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgJudgeCnt  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDryCnt    = 3'd5;

  // register reset values
  localparam logic [MvW-1:0]  WetThrRst    = 12'd452;
  localparam logic [MvW-1:0]  ShortThrRst  = 12'd1200;
  localparam logic [MvW-1:0]  GroundThrRst = 12'd30;
  localparam logic [CntW-1:0] JudgeCntRst  = 4'd10;
  localparam logic [CntW-1:0] DryCntRst    = 4'd10;

  // delays in ms
  localparam logic [DelayW-1:0] JudgeDelay    = 21'd250;
  localparam logic [DelayW-1:0] DryStepDelay  = 21'd1000;
  localparam logic [DelayW-1:0] WetRetryDelay = 21'd10000;

  typedef struct packed {
    logic [MvW-1:0]  wet_thr;
    logic [MvW-1:0]  short_thr;
    logic [MvW-1:0]  ground_thr;
    logic            logo_mode;
    logic [CntW-1:0] judge_cnt;
    logic [CntW-1:0] dry_cnt;
  } mwd_cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [CntW-1:0]    sample_count;
    logic [CntW-1:0]    wet_count;
    logic [CntW-1:0]    dry_run;
    logic [LevelW-1:0]  level;
    logic [RepeatW-1:0] repeat_count;
    logic               moisture;
    logic               cc_on;
  } mwd_state_t;

  typedef struct packed {
    logic               req_type;
    logic [MvW-1:0]     sbu_mv;
    logic               cc_wet;
    logic               charger_present;
    logic               overvoltage;
  } mwd_item_t;

  typedef struct packed {
    logic              moisture;
    logic              cc_detect_enable;
    logic [PhaseW-1:0] phase;
    logic [DelayW-1:0] next_delay_ms;
    logic [LevelW-1:0] backoff_level;
  } mwd_res_t;

  // backoff recheck time per level, last entry repeats
  function automatic logic [DelayW-1:0] backoff_time(input logic [LevelW-1:0] lvl);
    logic [DelayW-1:0] t;
    case (lvl)
      3'd0:    t = 21'd1000;
      3'd1:    t = 21'd6000;
      3'd2:    t = 21'd60000;
      3'd3:    t = 21'd600000;
      default: t = 21'd1800000;
    endcase
    return t;
  endfunction

  // repeats allowed at each level before moving up
  function automatic logic [RepeatW-1:0] backoff_repeat(input logic [LevelW-1:0] lvl);
    logic [RepeatW-1:0] r;
    case (lvl)
      3'd0:    r = 15'd1;
      3'd1:    r = 15'd1;
      3'd2:    r = 15'd10;
      3'd3:    r = 15'd12;
      default: r = 15'd32767;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mwd_if.sv -----
// valid/ready channel interfaces for measurement items and results
interface mwd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [mwd_pkg::MvW-1:0]  sbu_mv;
  logic                     cc_wet;
  logic                     charger_present;
  logic                     overvoltage;

  modport source (output valid, req_type, sbu_mv, cc_wet, charger_present, overvoltage,
                  input ready);
  modport sink   (input valid, req_type, sbu_mv, cc_wet, charger_present, overvoltage,
                  output ready);
endinterface

interface mwd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        moisture;
  logic                        cc_detect_enable;
  logic [mwd_pkg::PhaseW-1:0]  phase;
  logic [mwd_pkg::DelayW-1:0]  next_delay_ms;
  logic [mwd_pkg::LevelW-1:0]  backoff_level;

  modport source (output valid, moisture, cc_detect_enable, phase, next_delay_ms,
                  backoff_level, input ready);
  modport sink   (input valid, moisture, cc_detect_enable, phase, next_delay_ms,
                  backoff_level, output ready);
endinterface

// ----- rtl/usb_moisture_wet_dry_controller_top.sv -----
// top level of the connector moisture wet/dry controller
// The controller takes one transaction per clock cycle on the input channel while the skid
// entry is free, and returns exactly one result transaction for each, in order. Start
// transactions (req_type 0) open a judging phase; measurement transactions (req_type 1)
// carry the SBU voltage, the CC wet status, charger presence and overvoltage. The result
// gives the moisture flag, whether CC detection should be on, the current phase, the delay
// in ms until the next measurement is due and the CC recheck backoff level. The state
// update and result are computed in a single pass of comparisons and small counter
// increments from the state registers and the accepted item, and land in the result or
// skid register. A two-entry output buffer (result register plus skid register) keeps the
// input ready while one result waits, so a sustained rate of one transaction per cycle
// holds whenever the sink takes results every cycle. Configuration registers are written
// through the plain write port and should only change while no transaction is in flight.
module usb_moisture_wet_dry_controller_top #(
  parameter int unsigned BACKOFF_LEVELS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mwd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mwd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  mwd_in_if.sink                        in_if,
  mwd_out_if.source                     out_if
);

  mwd_pkg::mwd_cfg_t   cfg_q;
  mwd_pkg::mwd_state_t state_q;
  mwd_pkg::mwd_state_t state_d;
  mwd_pkg::mwd_item_t  item;
  mwd_pkg::mwd_res_t   res_d;
  mwd_pkg::mwd_res_t   res_q;
  mwd_pkg::mwd_res_t   skid_q;
  logic                res_valid_q;
  logic                skid_valid_q;
  logic                in_fire;
  logic                out_fire;

  // input handshake: stall only when the skid entry is occupied
  assign in_if.ready = !skid_valid_q;
  assign in_fire     = in_if.valid && !skid_valid_q;
  assign out_fire    = res_valid_q && out_if.ready;

  assign item.req_type        = in_if.req_type;
  assign item.sbu_mv          = in_if.sbu_mv;
  assign item.cc_wet          = in_if.cc_wet;
  assign item.charger_present = in_if.charger_present;
  assign item.overvoltage     = in_if.overvoltage;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wet_thr    <= mwd_pkg::WetThrRst;
      cfg_q.short_thr  <= mwd_pkg::ShortThrRst;
      cfg_q.ground_thr <= mwd_pkg::GroundThrRst;
      cfg_q.logo_mode  <= 1'b0;
      cfg_q.judge_cnt  <= mwd_pkg::JudgeCntRst;
      cfg_q.dry_cnt    <= mwd_pkg::DryCntRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mwd_pkg::CfgWetThr:    cfg_q.wet_thr    <= cfg_wdata_i;
        mwd_pkg::CfgShortThr:  cfg_q.short_thr  <= cfg_wdata_i;
        mwd_pkg::CfgGroundThr: cfg_q.ground_thr <= cfg_wdata_i;
        mwd_pkg::CfgLogoMode:  cfg_q.logo_mode  <= cfg_wdata_i[0];
        mwd_pkg::CfgJudgeCnt:  cfg_q.judge_cnt  <= cfg_wdata_i[mwd_pkg::CntW-1:0];
        mwd_pkg::CfgDryCnt:    cfg_q.dry_cnt    <= cfg_wdata_i[mwd_pkg::CntW-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // per-item decision logic
  mwd_core #(
    .BACKOFF_LEVELS (BACKOFF_LEVELS)
  ) u_core (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // controller state, advanced once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= mwd_pkg::PhDry;
      state_q.sample_count <= '0;
      state_q.wet_count    <= '0;
      state_q.dry_run      <= '0;
      state_q.level        <= '0;
      state_q.repeat_count <= '0;
      state_q.moisture     <= 1'b0;
      state_q.cc_on        <= 1'b1;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // output buffer: result register with a skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!res_valid_q || out_fire) begin
      if (skid_valid_q) begin
        res_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        res_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (!res_valid_q || out_fire) begin
      if (skid_valid_q) begin
        res_q <= skid_q;
      end else if (in_fire) begin
        res_q <= res_d;
      end
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign out_if.valid            = res_valid_q;
  assign out_if.moisture         = res_q.moisture;
  assign out_if.cc_detect_enable = res_q.cc_detect_enable;
  assign out_if.phase            = res_q.phase;
  assign out_if.next_delay_ms    = res_q.next_delay_ms;
  assign out_if.backoff_level    = res_q.backoff_level;

  // the skid entry is only filled behind a waiting result
  a_skid_behind_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> res_valid_q)
    else $error("skid entry valid without a result in front");

  // a dry connector is never flagged wet
  a_dry_not_wet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == mwd_pkg::PhDry) |-> !state_q.moisture)
    else $error("moisture flag set in dry phase");

  // waiting, dry run and cc check only follow a wet verdict
  a_wet_phases_flagged : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q.phase == mwd_pkg::PhWet) || (state_q.phase == mwd_pkg::PhDryRun) ||
     (state_q.phase == mwd_pkg::PhCc)) |-> state_q.moisture)
    else $error("wet phase without moisture flag");

  // backoff level stays within the configured ceiling
  a_level_ceiling : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level <= mwd_pkg::LevelW'(BACKOFF_LEVELS - 1))
    else $error("backoff level above ceiling");

  // state only moves on an accepted transaction
  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("state changed without a transaction");

endmodule

// ----- rtl/mwd_core.sv -----
// next-state and result logic for one item of the moisture controller
module mwd_core #(
  parameter int unsigned BACKOFF_LEVELS = 5
) (
  input  mwd_pkg::mwd_cfg_t   cfg_i,
  input  mwd_pkg::mwd_state_t state_i,
  input  mwd_pkg::mwd_item_t  item_i,
  output mwd_pkg::mwd_state_t state_o,
  output mwd_pkg::mwd_res_t   res_o
);

  localparam logic [mwd_pkg::LevelW-1:0] TopLevel = mwd_pkg::LevelW'(BACKOFF_LEVELS - 1);

  logic                             is_wet;
  logic                             is_dry;
  logic                             is_short;
  logic [mwd_pkg::CntW-1:0]         need;
  logic [mwd_pkg::CntW-1:0]         samp_inc;
  logic [mwd_pkg::CntW-1:0]         wet_inc;
  logic [mwd_pkg::CntW-1:0]         dry_inc;
  logic [mwd_pkg::LevelW-1:0]       lvl_clamp;
  logic [mwd_pkg::LevelW-1:0]       lvl_next;
  logic [mwd_pkg::DelayW-1:0]       delay;
  mwd_pkg::mwd_state_t              st;

  assign is_wet   = (item_i.sbu_mv < cfg_i.wet_thr) && (item_i.sbu_mv > cfg_i.ground_thr);
  assign is_dry   = !item_i.charger_present &&
                    (((item_i.sbu_mv >= cfg_i.wet_thr) && (item_i.sbu_mv <= cfg_i.short_thr))
                     || (item_i.sbu_mv <= cfg_i.ground_thr));
  assign is_short = item_i.sbu_mv >= cfg_i.short_thr;
  assign need     = (cfg_i.judge_cnt == '0) ? mwd_pkg::CntW'(1) : cfg_i.judge_cnt;
  assign samp_inc = state_i.sample_count + mwd_pkg::CntW'(1);
  assign wet_inc  = state_i.wet_count + (is_wet ? mwd_pkg::CntW'(1) : '0);
  assign dry_inc  = state_i.dry_run + mwd_pkg::CntW'(1);
  assign lvl_clamp = (state_i.level > TopLevel) ? TopLevel : state_i.level;
  assign lvl_next  = (lvl_clamp < TopLevel) ? lvl_clamp + mwd_pkg::LevelW'(1) : lvl_clamp;

  always_comb begin
    st    = state_i;
    delay = '0;
    if (item_i.req_type == mwd_pkg::ReqStart) begin
      st.phase        = mwd_pkg::PhJudge;
      st.sample_count = '0;
      st.wet_count    = '0;
      st.cc_on        = 1'b1;
      delay           = mwd_pkg::JudgeDelay;
    end else begin
      case (state_i.phase)
        mwd_pkg::PhJudge: begin
          st.cc_on = 1'b0;
          if (item_i.charger_present) begin
            st.phase    = mwd_pkg::PhDry;
            st.moisture = 1'b0;
            st.cc_on    = 1'b1;
          end else if (cfg_i.logo_mode && (is_short || item_i.overvoltage)) begin
            st.phase    = mwd_pkg::PhWet;
            st.moisture = 1'b1;
          end else begin
            st.wet_count    = wet_inc;
            st.sample_count = samp_inc;
            if (samp_inc >= need) begin
              if (wet_inc >= need) begin
                st.phase    = mwd_pkg::PhWet;
                st.moisture = 1'b1;
              end else begin
                st.phase    = mwd_pkg::PhDry;
                st.moisture = 1'b0;
                st.cc_on    = 1'b1;
              end
            end else begin
              delay = mwd_pkg::JudgeDelay;
            end
          end
        end
        mwd_pkg::PhWet: begin
          st.cc_on = 1'b0;
          if (is_dry) begin
            if (cfg_i.dry_cnt == '0) begin
              st.phase        = mwd_pkg::PhCc;
              st.level        = '0;
              st.repeat_count = '0;
            end else begin
              st.phase   = mwd_pkg::PhDryRun;
              st.dry_run = '0;
              delay      = mwd_pkg::DryStepDelay;
            end
          end else begin
            delay = mwd_pkg::WetRetryDelay;
          end
        end
        mwd_pkg::PhDryRun: begin
          st.cc_on = 1'b0;
          if (is_dry) begin
            st.dry_run = dry_inc;
            if (dry_inc >= cfg_i.dry_cnt) begin
              st.phase        = mwd_pkg::PhCc;
              st.level        = '0;
              st.repeat_count = '0;
            end else begin
              delay = mwd_pkg::DryStepDelay;
            end
          end else begin
            st.phase   = mwd_pkg::PhWet;
            st.dry_run = '0;
            delay      = mwd_pkg::WetRetryDelay;
          end
        end
        mwd_pkg::PhCc: begin
          if (!item_i.cc_wet) begin
            st.phase        = mwd_pkg::PhDry;
            st.moisture     = 1'b0;
            st.cc_on        = 1'b1;
            st.level        = '0;
            st.repeat_count = '0;
          end else begin
            st.cc_on = 1'b0;
            if (state_i.repeat_count >= mwd_pkg::backoff_repeat(lvl_clamp)) begin
              st.repeat_count = '0;
              st.level        = lvl_next;
            end else begin
              st.repeat_count = state_i.repeat_count + mwd_pkg::RepeatW'(1);
              st.level        = lvl_clamp;
            end
            delay = mwd_pkg::backoff_time(st.level);
          end
        end
        default: begin
          // dry, or an unused code: nothing due
          st.phase = mwd_pkg::PhDry;
          st.cc_on = 1'b1;
        end
      endcase
    end
  end

  assign state_o                = st;
  assign res_o.moisture         = st.moisture;
  assign res_o.cc_detect_enable = st.cc_on;
  assign res_o.phase            = st.phase;
  assign res_o.next_delay_ms    = delay;
  assign res_o.backoff_level    = st.level;

endmodule
